// File: src/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types, codes and the control store for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY = 64;
    localparam int IW       = $clog2(CAPACITY + 1);
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_EXTRACT = 2'd1;
    localparam logic [1:0] CMD_PEEK    = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] item_priority;
        logic [15:0] item_tag;
    } t_bmhq_req;

    typedef struct packed {
        logic [15:0] out_priority;
        logic [15:0] out_tag;
        logic [1:0]  status;
        logic [6:0]  entry_count_out;
    } t_bmhq_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_INS, S_UP_TEST, S_UP_CMP, S_UP_WR,
        S_EXT, S_EXT_ROOT, S_EXT_LAST,
        S_DN_L, S_DN_R, S_DN_RC, S_DN_DEC, S_DN_WR,
        S_DONE
    } t_step;

    typedef enum logic [2:0] {
        R_NONE, R_PARENT, R_ROOT, R_LAST, R_LEFT, R_RIGHT
    } t_rdsel;

    typedef enum logic [1:0] {
        W_NONE, W_CUR, W_RDATA, W_BEST
    } t_wrsel;

    typedef enum logic [3:0] {
        A_NONE, A_LATCH, A_INS, A_EXT, A_ROOT, A_LAST, A_UP,
        A_DN_INIT, A_PICK_L, A_PICK_R, A_DESCEND, A_DONE
    } t_act;

    typedef enum logic [3:0] {
        C_ALWAYS, C_DISPATCH, C_FULL, C_AT_ROOT, C_PAR_LESS, C_EMPTY,
        C_PEEK, C_ONE_LEFT, C_NO_LEFT, C_NO_RIGHT, C_MOVED, C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_rdsel rd;
        t_wrsel wr;
        logic   wr_gated;
        t_act   act;
        t_cond  cond;
        t_step  tgt_t;
        t_step  tgt_f;
    } t_uword;

    function automatic logic [15:0] prio_of(input logic [31:0] w);
        return w[31:16];
    endfunction

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '{rd: R_NONE, wr: W_NONE, wr_gated: 1'b0, act: A_NONE,
              cond: C_ALWAYS, tgt_t: S_IDLE, tgt_f: S_IDLE};
        case (s)
            S_IDLE: begin
                w.act = A_LATCH; w.cond = C_DISPATCH;
            end
            S_INS: begin
                w.act = A_INS; w.cond = C_FULL;
                w.tgt_t = S_DONE; w.tgt_f = S_UP_TEST;
            end
            S_UP_TEST: begin
                w.rd = R_PARENT; w.cond = C_AT_ROOT;
                w.tgt_t = S_UP_WR; w.tgt_f = S_UP_CMP;
            end
            S_UP_CMP: begin
                w.wr = W_RDATA; w.wr_gated = 1'b1; w.act = A_UP;
                w.cond = C_PAR_LESS; w.tgt_t = S_UP_TEST; w.tgt_f = S_UP_WR;
            end
            S_UP_WR: begin
                w.wr = W_CUR; w.tgt_t = S_DONE;
            end
            S_EXT: begin
                w.rd = R_ROOT; w.act = A_EXT; w.cond = C_EMPTY;
                w.tgt_t = S_DONE; w.tgt_f = S_EXT_ROOT;
            end
            S_EXT_ROOT: begin
                w.rd = R_LAST; w.act = A_ROOT; w.cond = C_PEEK;
                w.tgt_t = S_DONE; w.tgt_f = S_EXT_LAST;
            end
            S_EXT_LAST: begin
                w.act = A_LAST; w.cond = C_ONE_LEFT;
                w.tgt_t = S_DONE; w.tgt_f = S_DN_L;
            end
            S_DN_L: begin
                w.rd = R_LEFT; w.act = A_DN_INIT; w.cond = C_NO_LEFT;
                w.tgt_t = S_DN_WR; w.tgt_f = S_DN_R;
            end
            S_DN_R: begin
                w.rd = R_RIGHT; w.act = A_PICK_L; w.cond = C_NO_RIGHT;
                w.tgt_t = S_DN_DEC; w.tgt_f = S_DN_RC;
            end
            S_DN_RC: begin
                w.act = A_PICK_R; w.tgt_t = S_DN_DEC;
            end
            S_DN_DEC: begin
                w.wr = W_BEST; w.wr_gated = 1'b1; w.act = A_DESCEND;
                w.cond = C_MOVED; w.tgt_t = S_DN_L; w.tgt_f = S_DN_WR;
            end
            S_DN_WR: begin
                w.wr = W_CUR; w.tgt_t = S_DONE;
            end
            S_DONE: begin
                w.act = A_DONE; w.cond = C_OUT_BUSY;
                w.tgt_t = S_DONE; w.tgt_f = S_IDLE;
            end
            default: begin
                w.tgt_t = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: src/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Bounded max-heap priority queue run by a microcoded step sequencer.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                  | payload
//  request  | in  | i_req_valid / o_req_stall  | i_req (t_bmhq_req)
//  response | out | o_rsp_valid / i_rsp_stall  | o_rsp (t_bmhq_rsp)
//
//  One request at a time. One heap RAM access per step, with registered read
//  data. Reset empties the heap at once (count cleared); RAM contents are not
//  cleared. A stalled response waits in the output register; the next request
//  is taken meanwhile, and its result waits for the register to free up.
// ----------------------------------------------------------------------------
module binary_max_heap_queue
    import bmhq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_stall,
    input  t_bmhq_req i_req,
    output logic      o_rsp_valid,
    input  logic      i_rsp_stall,
    output t_bmhq_rsp o_rsp
);

    logic [31:0]   r_mem [CAPACITY];
    logic [31:0]   r_rdata;
    t_step         r_step, n_step;
    logic [IW-1:0] r_count;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_bidx;
    logic [1:0]    r_cmd;
    logic [31:0]   r_cur;
    logic [31:0]   r_best;
    logic [15:0]   r_res_prio;
    logic [15:0]   r_res_tag;
    t_status       r_res_status;
    t_bmhq_rsp     r_out;
    logic          r_out_valid;

    t_uword        uw;
    logic          cond_true;
    logic          req_acc;
    logic          out_free;
    logic [IW:0]   child;
    logic [IW:0]   child_p1;
    logic [IW:0]   child_m1;
    logic [IW:0]   cnt_x;
    logic [IW-1:0] par_m1;
    logic [IW-1:0] cnt_m1;
    logic [IW-1:0] idx_m1;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          wr_en;
    t_step         dispatch;

    assign uw          = ucode(r_step);
    assign o_req_stall = (r_step != S_IDLE);
    assign req_acc     = i_req_valid && !o_req_stall;
    assign out_free    = !r_out_valid || !i_rsp_stall;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    assign child    = {r_idx, 1'b0};
    assign child_p1 = child + (IW+1)'(1);
    assign child_m1 = child - (IW+1)'(1);
    assign cnt_x    = {1'b0, r_count};
    assign par_m1   = (r_idx >> 1) - IW'(1);
    assign cnt_m1   = r_count - IW'(1);
    assign idx_m1   = r_idx - IW'(1);

    always_comb begin
        case (uw.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_DISPATCH: cond_true = req_acc;
            C_FULL:     cond_true = (r_count >= IW'(CAPACITY));
            C_AT_ROOT:  cond_true = (r_idx == IW'(1));
            C_PAR_LESS: cond_true = (prio_of(r_rdata) < prio_of(r_cur));
            C_EMPTY:    cond_true = (r_count == '0);
            C_PEEK:     cond_true = (r_cmd == CMD_PEEK);
            C_ONE_LEFT: cond_true = (r_count == IW'(1));
            C_NO_LEFT:  cond_true = (child > cnt_x);
            C_NO_RIGHT: cond_true = (child_p1 > cnt_x);
            C_MOVED:    cond_true = (r_bidx != r_idx);
            C_OUT_BUSY: cond_true = !out_free;
            default:    cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (i_req.command == CMD_INSERT) begin
            dispatch = S_INS;
        end else if (i_req.command inside {CMD_EXTRACT, CMD_PEEK}) begin
            dispatch = S_EXT;
        end else begin
            dispatch = S_DONE;
        end
    end

    always_comb begin
        if (uw.cond == C_DISPATCH) begin
            n_step = req_acc ? dispatch : S_IDLE;
        end else begin
            n_step = cond_true ? uw.tgt_t : uw.tgt_f;
        end
    end

    always_comb begin
        case (uw.rd)
            R_PARENT: rd_addr = par_m1[AW-1:0];
            R_ROOT:   rd_addr = '0;
            R_LAST:   rd_addr = cnt_m1[AW-1:0];
            R_LEFT:   rd_addr = child_m1[AW-1:0];
            R_RIGHT:  rd_addr = child[AW-1:0];
            default:  rd_addr = '0;
        endcase
    end

    always_comb begin
        case (uw.wr)
            W_CUR:   wr_data = r_cur;
            W_RDATA: wr_data = r_rdata;
            W_BEST:  wr_data = r_best;
            default: wr_data = r_cur;
        endcase
    end

    assign wr_en   = (uw.wr != W_NONE) && (!uw.wr_gated || cond_true);
    assign wr_addr = idx_m1[AW-1:0];

    // heap RAM: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (uw.act == A_INS && !cond_true) begin
                r_count <= r_count + IW'(1);
            end else if (uw.act == A_LAST) begin
                r_count <= cnt_m1;
            end
            if (uw.act == A_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (uw.act)
            A_LATCH: begin
                if (req_acc) begin
                    r_cmd        <= i_req.command;
                    r_cur        <= {i_req.item_priority, i_req.item_tag};
                    r_res_prio   <= '0;
                    r_res_tag    <= '0;
                    r_res_status <= ST_OK;
                end
            end
            A_INS: begin
                if (cond_true) begin
                    r_res_status <= ST_FULL;
                end else begin
                    r_idx <= r_count + IW'(1);
                end
            end
            A_EXT: begin
                if (cond_true) begin
                    r_res_status <= ST_EMPTY;
                end
            end
            A_ROOT: begin
                r_res_prio <= r_rdata[31:16];
                r_res_tag  <= r_rdata[15:0];
            end
            A_LAST: begin
                r_cur <= r_rdata;
                r_idx <= IW'(1);
            end
            A_UP: begin
                if (cond_true) begin
                    r_idx <= r_idx >> 1;
                end
            end
            A_DN_INIT: begin
                r_best <= r_cur;
                r_bidx <= r_idx;
            end
            A_PICK_L: begin
                if (prio_of(r_rdata) > prio_of(r_best)) begin
                    r_best <= r_rdata;
                    r_bidx <= child[IW-1:0];
                end
            end
            A_PICK_R: begin
                if (prio_of(r_rdata) > prio_of(r_best)) begin
                    r_best <= r_rdata;
                    r_bidx <= child_p1[IW-1:0];
                end
            end
            A_DESCEND: begin
                if (cond_true) begin
                    r_idx <= r_bidx;
                end
            end
            A_DONE: begin
                if (out_free) begin
                    r_out.out_priority    <= r_res_prio;
                    r_out.out_tag         <= r_res_tag;
                    r_out.status          <= r_res_status;
                    r_out.entry_count_out <= 7'(r_count);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: src/bmhq_checker.sv
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks on the heap queue responses, bound to the top level.
// ----------------------------------------------------------------------------
module bmhq_checker
    import bmhq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_req_valid,
    input logic      o_req_stall,
    input t_bmhq_req i_req,
    input logic      o_rsp_valid,
    input logic      i_rsp_stall,
    input t_bmhq_rsp o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_OK |->
            o_rsp.out_priority == '0 && o_rsp.out_tag == '0)
        else $error("error response carries an entry");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == ST_FULL |->
            o_rsp.entry_count_out == 7'(CAPACITY))
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == ST_EMPTY |-> o_rsp.entry_count_out == '0)
        else $error("empty status with entries held");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.status == ST_OK || o_rsp.status == ST_EMPTY ||
            o_rsp.status == ST_FULL)
        else $error("undefined status code");

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (.*);

// File: test/tb_binary_max_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_max_heap_queue
// Self-checking bench for the max-heap priority queue. A shadow heap follows
// every accepted request and predicts its result: root entry, status, count.
// Directed corner requests come first, then random fill / drain / mixed
// phases with narrow and wide priority ranges, the later ones under random
// valid gaps and response stalls on both sides.
// ----------------------------------------------------------------------------
import bmhq_pkg::*;

class heap_shadow;
    logic [31:0] slots [0:CAPACITY];
    int unsigned held;
    t_bmhq_rsp   owed_results [$];
    int unsigned mismatches;

    function new();
        foreach (slots[i]) slots[i] = '0;
        held       = 0;
        mismatches = 0;
    endfunction

    function void swap_slots(input int unsigned a, input int unsigned b);
        logic [31:0] t;
        t        = slots[a];
        slots[a] = slots[b];
        slots[b] = t;
    endfunction

    function void owe_result(input t_bmhq_rsp e);
        owed_results = {owed_results, e};
    endfunction

    function void apply_command(input t_bmhq_req r);
        t_bmhq_rsp   e;
        int unsigned idx, best, lc, rc;
        bit          settled;
        logic [31:0] top;
        e       = '0;
        settled = 1'b0;
        case (r.command)
            CMD_INSERT: begin
                if (held >= CAPACITY) begin
                    e.status = ST_FULL;
                end else begin
                    held++;
                    slots[held] = {r.item_priority, r.item_tag};
                    idx = held;
                    while (idx > 1 && !settled) begin
                        if (slots[idx / 2][31:16] < slots[idx][31:16]) begin
                            swap_slots(idx / 2, idx);
                            idx = idx / 2;
                        end else begin
                            settled = 1'b1;
                        end
                    end
                end
            end
            CMD_EXTRACT, CMD_PEEK: begin
                if (held == 0) begin
                    e.status = ST_EMPTY;
                end else begin
                    top            = slots[1];
                    e.out_priority = top[31:16];
                    e.out_tag      = top[15:0];
                    if (r.command == CMD_EXTRACT) begin
                        slots[1] = slots[held];
                        held--;
                        idx = 1;
                        while (!settled) begin
                            best = idx;
                            lc   = 2 * idx;
                            rc   = lc + 1;
                            if (lc <= held && slots[lc][31:16] > slots[best][31:16])
                                best = lc;
                            if (rc <= held && slots[rc][31:16] > slots[best][31:16])
                                best = rc;
                            if (best == idx) begin
                                settled = 1'b1;
                            end else begin
                                swap_slots(idx, best);
                                idx = best;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        e.entry_count_out = held[6:0];
        owe_result(e);
    endfunction

    function void check_result(input t_bmhq_rsp got);
        t_bmhq_rsp e;
        if (owed_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected response: prio %h tag %h status %0d count %0d",
                         got.out_priority, got.out_tag, got.status, got.entry_count_out);
        end else begin
            e = owed_results.pop_front();
            if (got.out_priority !== e.out_priority || got.out_tag !== e.out_tag ||
                got.status !== e.status || got.entry_count_out !== e.entry_count_out) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp prio %h tag %h status %0d count %0d / %s %h %h %0d %0d",
                             e.out_priority, e.out_tag, e.status, e.entry_count_out,
                             "got", got.out_priority, got.out_tag, got.status,
                             got.entry_count_out);
            end
        end
    endfunction
endclass

module tb_binary_max_heap_queue;
    import bmhq_pkg::*;

    localparam logic [1:0]  CMD_NOP    = 2'd3;
    localparam int unsigned CYCLE_CAP  = 400000;
    localparam int unsigned RAND_ITEMS = 800;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIX} t_phase;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    t_bmhq_req req       = '0;
    logic      rsp_stall = 1'b0;
    logic      req_stall;
    logic      rsp_valid;
    t_bmhq_rsp rsp;

    bit          gaps_on = 1'b0;
    int unsigned cycles  = 0;
    heap_shadow  shadow  = new();

    binary_max_heap_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall)
            shadow.check_result(rsp);
        rsp_stall <= gaps_on && ($urandom_range(99) < 26);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_request(input logic [1:0] cmd, input logic [15:0] pr,
                                input logic [15:0] tg);
        t_bmhq_req r;
        r.command       = cmd;
        r.item_priority = pr;
        r.item_tag      = tg;
        if (gaps_on && $urandom_range(99) < 26) begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 26);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        shadow.apply_command(r);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (shadow.owed_results.size() != 0);
    endtask

    initial begin
        t_phase      ph;
        int unsigned sent, plen, span, roll;
        logic [1:0]  cmd;
        logic [15:0] pr;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty heap, no-op, extremes and equal priorities
        push_request(CMD_EXTRACT, 16'h0000, 16'h0000);
        push_request(CMD_PEEK,    16'hffff, 16'hffff);
        push_request(CMD_NOP,     16'hffff, 16'hffff);
        push_request(CMD_INSERT,  16'h0000, 16'h0000);
        push_request(CMD_PEEK,    16'h0000, 16'h0000);
        push_request(CMD_INSERT,  16'hffff, 16'hffff);
        push_request(CMD_INSERT,  16'h8000, 16'h0001);
        push_request(CMD_INSERT,  16'h8000, 16'h0002);
        push_request(CMD_INSERT,  16'h8000, 16'h0003);
        push_request(CMD_INSERT,  16'h0001, 16'ha5a5);
        push_request(CMD_INSERT,  16'h7fff, 16'h5a5a);
        push_request(CMD_NOP,     16'h1234, 16'h5678);
        push_request(CMD_PEEK,    16'h0000, 16'h0000);
        repeat (8) push_request(CMD_EXTRACT, 16'h0000, 16'h0000);
        wait_drained();

        sent = 0;
        while (sent < RAND_ITEMS) begin
            ph   = (sent == 0) ? PH_FILL : t_phase'($urandom_range(2));
            plen = (sent == 0) ? 110 : $urandom_range(40, 120);
            span = $urandom_range(2);
            gaps_on = (sent >= 200);
            repeat (plen) begin
                roll = $urandom_range(99);
                case (ph)
                    PH_FILL:  cmd = roll < 85 ? CMD_INSERT : roll < 93 ? CMD_PEEK :
                                    roll < 98 ? CMD_EXTRACT : CMD_NOP;
                    PH_DRAIN: cmd = roll < 70 ? CMD_EXTRACT : roll < 85 ? CMD_PEEK :
                                    roll < 97 ? CMD_INSERT : CMD_NOP;
                    default:  cmd = roll < 45 ? CMD_INSERT : roll < 80 ? CMD_EXTRACT :
                                    roll < 95 ? CMD_PEEK : CMD_NOP;
                endcase
                case (span)
                    0:       pr = 16'($urandom_range(3));
                    1:       pr = 16'($urandom_range(255));
                    default: pr = 16'($urandom_range(16'hffff));
                endcase
                push_request(cmd, pr, 16'($urandom_range(16'hffff)));
                sent++;
            end
            if ($urandom_range(3) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.owed_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
src/bmhq_pkg.sv
src/binary_max_heap_queue.sv
src/bmhq_checker.sv
test/tb_binary_max_heap_queue.sv
